FILE: design/mmu_pkg.sv
// Shared constants, codes and word types for the 4x4 fixed-point matrix unit.
// No dependencies; imported by matrix4x4_unit.
package mmu_pkg;

   localparam int MATRIX_DIM = 4;
   localparam int FRAC_BITS  = 16;
   localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
   localparam int IDX_W      = $clog2(ELEM_COUNT);
   localparam int CNT_W      = $clog2(MATRIX_DIM);
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int ACC_W      = PROD_W - FRAC_BITS + $clog2(MATRIX_DIM);
   localparam int OP_W       = 3;

   localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
   localparam logic [OP_W-1:0] OP_MUL   = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd3;
   localparam logic [OP_W-1:0] OP_CMP   = 3'd4;
   localparam logic [OP_W-1:0] OP_TRN   = 3'd5;
   localparam logic [OP_W-1:0] OP_IDENT = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic                     matrix_select;
      logic [IDX_W-1:0]         element_index;
      logic signed [DATA_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_index;
      logic signed [DATA_W-1:0] out_value;
      logic                     is_equal;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             last;
      logic             first_k;
      logic             last_k;
   } tag_type;

   function automatic logic [IDX_W-1:0] elem_addr(input logic [CNT_W-1:0] row,
                                                  input logic [CNT_W-1:0] col);
      return IDX_W'(row) * IDX_W'(MATRIX_DIM) + IDX_W'(col);
   endfunction

endpackage

FILE: design/matrix4x4_unit.sv
// 4x4 signed Q16.16 matrix unit: matrices A and B in two synchronous memories,
// one shared multiply-accumulate path. Depends on mmu_pkg.
//
// A word is taken when start is high and busy is low. Write and identity finish
// in the accepting cycle and leave busy low. Add, subtract, transpose and compare
// read both memories once per element. Multiply runs 64 multiply-accumulates
// through the one shared multiplier, one per cycle. Results appear on rsp_data
// for exactly one cycle with rsp_strobe high and cannot be held off; take each
// word when it is shown. Both matrices are identity right after reset, with no
// clearing pass. Transpose flips an address map and costs no memory rewrite.
module matrix4x4_unit
   import mmu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [CNT_W-1:0]      row_ff, row_in;
   logic [CNT_W-1:0]      col_ff, col_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic                  tr_ff, tr_in;
   logic                  eq_ff, eq_in;
   logic [ELEM_COUNT-1:0] valid_a_ff, valid_a_in;
   logic [ELEM_COUNT-1:0] valid_b_ff, valid_b_in;

   logic [DATA_W-1:0]     mem_a [ELEM_COUNT];
   logic [DATA_W-1:0]     mem_b [ELEM_COUNT];
   logic [DATA_W-1:0]     rd_a_ff, rd_b_ff;

   logic                  s1_valid_ff, s1_valid_in;
   tag_type               s1_tag_ff, s1_tag_in;
   logic                  rdv_a_ff, rdv_a_in, rdv_b_ff, rdv_b_in;
   logic                  diag_a_ff, diag_a_in, diag_b_ff, diag_b_in;

   logic                  s2_valid_ff, s2_valid_in;
   tag_type               s2_tag_ff, s2_tag_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  is_mul, last_k, last_col, last_row;
   logic [CNT_W-1:0]      a_row, a_col, b_row, b_col;
   logic [IDX_W-1:0]      rd_addr_a, rd_addr_b;
   logic                  we_a, we_b, idx_ok;
   logic [CNT_W-1:0]      wr_row, wr_col;
   logic [IDX_W-1:0]      wr_addr_a;
   logic signed [DATA_W-1:0] a_eff, b_eff;
   logic signed [DATA_W:0]   add_sum;
   logic signed [ACC_W-1:0]  term, acc_sum;
   logic [ACC_W-DATA_W:0]    acc_top;

   assign busy       = (state_ff != ST_IDLE) || s1_valid_ff || s2_valid_ff;
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   assign is_mul   = (op_ff == OP_MUL);
   assign last_k   = !is_mul || (k_ff == CNT_W'(MATRIX_DIM - 1));
   assign last_col = (col_ff == CNT_W'(MATRIX_DIM - 1));
   assign last_row = (row_ff == CNT_W'(MATRIX_DIM - 1));

   assign a_row = row_ff;
   assign a_col = is_mul ? k_ff : col_ff;
   assign b_row = is_mul ? k_ff : row_ff;
   assign b_col = col_ff;
   assign rd_addr_a = tr_ff ? elem_addr(a_col, a_row) : elem_addr(a_row, a_col);
   assign rd_addr_b = elem_addr(b_row, b_col);

   assign idx_ok    = {1'b0, req_data.element_index} < (IDX_W + 1)'(ELEM_COUNT);
   assign wr_row    = CNT_W'(req_data.element_index / MATRIX_DIM);
   assign wr_col    = CNT_W'(req_data.element_index % MATRIX_DIM);
   assign wr_addr_a = tr_ff ? elem_addr(wr_col, wr_row) : req_data.element_index;
   assign we_a = accept && (req_data.operation == OP_WRITE) && !req_data.matrix_select
                 && idx_ok;
   assign we_b = accept && (req_data.operation == OP_WRITE) && req_data.matrix_select
                 && idx_ok;

   assign a_eff = rdv_a_ff ? $signed(rd_a_ff) : (diag_a_ff ? $signed(FIX_ONE) : '0);
   assign b_eff = rdv_b_ff ? $signed(rd_b_ff) : (diag_b_ff ? $signed(FIX_ONE) : '0);
   assign prod_in = a_eff * b_eff;
   assign add_sum = (op_ff == OP_SUB) ? (DATA_W + 1)'(a_eff) - (DATA_W + 1)'(b_eff)
                                      : (DATA_W + 1)'(a_eff) + (DATA_W + 1)'(b_eff);

   assign term    = ACC_W'($signed(prod_ff[PROD_W-1:FRAC_BITS]));
   assign acc_sum = (s2_tag_ff.first_k ? '0 : acc_ff) + term;
   assign acc_top = acc_sum[ACC_W-1:DATA_W-1];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      k_in          = k_ff;
      tr_in         = tr_ff;
      eq_in         = eq_ff;
      valid_a_in    = valid_a_ff;
      valid_b_in    = valid_b_ff;
      s1_valid_in   = 1'b0;
      s1_tag_in     = s1_tag_ff;
      rdv_a_in      = rdv_a_ff;
      rdv_b_in      = rdv_b_ff;
      diag_a_in     = diag_a_ff;
      diag_b_in     = diag_b_ff;
      s2_valid_in   = s1_valid_ff && is_mul;
      s2_tag_in     = s1_tag_ff;
      acc_in        = acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.operation inside {OP_MUL, OP_ADD, OP_SUB, OP_CMP, OP_TRN}) begin
                  state_in = ST_RUN;
                  op_in    = req_data.operation;
                  row_in   = '0;
                  col_in   = '0;
                  k_in     = '0;
                  eq_in    = 1'b1;
                  if (req_data.operation == OP_TRN) begin
                     tr_in = !tr_ff;
                  end
               end
               if (req_data.operation == OP_IDENT) begin
                  if (req_data.matrix_select) begin
                     valid_b_in = '0;
                  end else begin
                     valid_a_in = '0;
                  end
               end
               if (we_a) begin
                  valid_a_in[wr_addr_a] = 1'b1;
               end
               if (we_b) begin
                  valid_b_in[req_data.element_index] = 1'b1;
               end
            end
         end
         ST_RUN: begin
            s1_valid_in       = 1'b1;
            s1_tag_in.index   = elem_addr(row_ff, col_ff);
            s1_tag_in.last    = last_row && last_col;
            s1_tag_in.first_k = (k_ff == '0);
            s1_tag_in.last_k  = last_k;
            rdv_a_in          = valid_a_ff[rd_addr_a];
            rdv_b_in          = valid_b_ff[rd_addr_b];
            diag_a_in         = (a_row == a_col);
            diag_b_in         = (b_row == b_col);
            if (last_k) begin
               k_in = '0;
               if (last_col) begin
                  col_in = '0;
                  if (last_row) begin
                     row_in   = '0;
                     state_in = ST_IDLE;
                  end else begin
                     row_in = row_ff + CNT_W'(1);
                  end
               end else begin
                  col_in = col_ff + CNT_W'(1);
               end
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (s1_valid_ff) begin
         case (op_ff)
            OP_ADD, OP_SUB: begin
               rsp_strobe_in         = 1'b1;
               rsp_data_in.out_index = s1_tag_ff.index;
               rsp_data_in.is_equal  = 1'b0;
               rsp_data_in.last      = s1_tag_ff.last;
               if (add_sum[DATA_W] != add_sum[DATA_W-1]) begin
                  rsp_data_in.out_value = add_sum[DATA_W] ? SAT_MIN : SAT_MAX;
               end else begin
                  rsp_data_in.out_value = add_sum[DATA_W-1:0];
               end
            end
            OP_TRN: begin
               rsp_strobe_in         = 1'b1;
               rsp_data_in.out_index = s1_tag_ff.index;
               rsp_data_in.out_value = a_eff;
               rsp_data_in.is_equal  = 1'b0;
               rsp_data_in.last      = s1_tag_ff.last;
            end
            OP_CMP: begin
               eq_in = eq_ff && (a_eff == b_eff);
               if (s1_tag_ff.last) begin
                  rsp_strobe_in         = 1'b1;
                  rsp_data_in.out_index = '0;
                  rsp_data_in.out_value = '0;
                  rsp_data_in.is_equal  = eq_in;
                  rsp_data_in.last      = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (s2_valid_ff) begin
         acc_in = acc_sum;
         if (s2_tag_ff.last_k) begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in.out_index = s2_tag_ff.index;
            rsp_data_in.is_equal  = 1'b0;
            rsp_data_in.last      = s2_tag_ff.last;
            if (&acc_top || ~|acc_top) begin
               rsp_data_in.out_value = acc_sum[DATA_W-1:0];
            end else begin
               rsp_data_in.out_value = acc_sum[ACC_W-1] ? SAT_MIN : SAT_MAX;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[wr_addr_a] <= req_data.element_value;
      end
      rd_a_ff <= mem_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[req_data.element_index] <= req_data.element_value;
      end
      rd_b_ff <= mem_b[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_WRITE;
         row_ff        <= '0;
         col_ff        <= '0;
         k_ff          <= '0;
         tr_ff         <= 1'b0;
         valid_a_ff    <= '0;
         valid_b_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         k_ff          <= k_in;
         tr_ff         <= tr_in;
         valid_a_ff    <= valid_a_in;
         valid_b_ff    <= valid_b_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      eq_ff       <= eq_in;
      s1_tag_ff   <= s1_tag_in;
      rdv_a_ff    <= rdv_a_in;
      rdv_b_ff    <= rdv_b_in;
      diag_a_ff   <= diag_a_in;
      diag_b_ff   <= diag_b_in;
      s2_tag_ff   <= s2_tag_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
